FILE: sv/frpd_pkg.sv
// Shared widths and types for the flipped row pair detector.
`default_nettype none

package frpd_pkg;

    // Width of the row field on the input stream.
    localparam int unsigned ROW_BITS_W = 32;
    // Width of the flip factor register.
    localparam int unsigned FLIP_W = 5;
    // Width of the packed result data (duplicate and overflow, padded to a byte).
    localparam int unsigned M_DATA_W = 8;

    // Per-cell control sent from the top level to each storage cell.
    typedef struct packed {
        logic shift_en;   // Store the incoming row and pass the held row on.
        logic compare_en; // The cell holds a current-table row and the flip index is in the row.
    } cell_ctl_t;

endpackage

`default_nettype wire

FILE: sv/frpd_cell.sv
// One storage cell of the row chain, with its own comparator.
`default_nettype none

module frpd_cell #(
    parameter int unsigned ROW_W = 32
) (
    input  wire logic              aclk,
    input  wire frpd_pkg::cell_ctl_t ctl,
    input  wire logic [ROW_W-1:0]  row_in,
    input  wire logic [ROW_W-1:0]  target,
    output logic      [ROW_W-1:0]  row_out,
    output logic                   match
);
    import frpd_pkg::*;

    logic [ROW_W-1:0] row_reg;

    // The stored row moves one cell along whenever a new row is stored.
    always_ff @(posedge aclk) begin
        if (ctl.shift_en) begin
            row_reg <= row_in;
        end
    end

    assign row_out = row_reg;
    assign match   = ctl.compare_en && (row_reg == target);

endmodule

`default_nettype wire

FILE: sv/flipped_row_pair_detector_top.sv
// Top level of the flipped row pair detector: row chain, flags and result register.
`default_nettype none

// Channel   | Direction | Payload
// ----------+-----------+-------------------------------------------------------
// s_        | in        | tdata[31:0] row_bits, tlast last_row
// m_        | out       | tdata[0] duplicate, tdata[1] overflow, tlast last_result
// cfg_wr_   | in        | data[4:0] flip_factor
//
// A row transaction is answered in the cycle after it is accepted; a new row can be
// accepted in every cycle, the limit being the single compare against all cells.
// The result sits in an output register, so the input keeps flowing while that
// register is empty or is being emptied in the same cycle.
// Reset clears the fill count, the flags, the flip factor and the output valid;
// the row cells hold undefined data until they are written and are never read
// before that because each cell compares only when it lies below the fill count.

module flipped_row_pair_detector_top #(
    parameter int unsigned FACTORS  = 32,
    parameter int unsigned MAX_ROWS = 64
) (
    input  wire logic                             aclk,
    input  wire logic                             aresetn,
    // Configuration write port for flip_factor.
    input  wire logic                             cfg_wr_en,
    input  wire logic [frpd_pkg::FLIP_W-1:0]      cfg_wr_data,
    // Row input stream.
    input  wire logic                             s_tvalid,
    output logic                                  s_tready,
    input  wire logic [frpd_pkg::ROW_BITS_W-1:0]  s_tdata,   // [31:0] row_bits
    input  wire logic                             s_tlast,   // last_row
    // Result output stream.
    output logic                                  m_tvalid,
    input  wire logic                             m_tready,
    output logic      [frpd_pkg::M_DATA_W-1:0]    m_tdata,   // [0] duplicate, [1] overflow
    output logic                                  m_tlast    // last_result
);
    import frpd_pkg::*;

    // Rows are held at the factor count; bits above it are dropped on entry.
    localparam int unsigned ROW_W = (FACTORS < ROW_BITS_W) ? FACTORS : ROW_BITS_W;
    localparam int unsigned CNT_W = $clog2(MAX_ROWS + 1);

    logic [FLIP_W-1:0]   flip_factor_reg;
    logic [CNT_W-1:0]    row_count_reg, row_count_next;
    logic                found_flag_reg, found_flag_next;
    logic                overflow_flag_reg, overflow_flag_next;
    logic                m_tvalid_reg;
    logic [M_DATA_W-1:0] m_tdata_reg;
    logic                m_tlast_reg;

    logic                s_accept;
    logic                store_full;
    logic [ROW_W-1:0]    row_in;
    logic [ROW_W-1:0]    flip_mask;
    logic                flip_in_row;
    logic [ROW_W-1:0]    target;
    logic [MAX_ROWS-1:0] match_vec;
    logic [ROW_W-1:0]    cell_row [0:MAX_ROWS-1];

    assign s_tready   = !m_tvalid_reg || m_tready;
    assign s_accept   = s_tvalid && s_tready;
    assign store_full = (row_count_reg == CNT_W'(MAX_ROWS));

    assign row_in = s_tdata[ROW_W-1:0];

    // A flip index that lies outside the row can never produce a match.
    assign flip_in_row = (32'(flip_factor_reg) < FACTORS);
    assign flip_mask   = flip_in_row ? (ROW_W'(1) << flip_factor_reg) : '0;
    assign target      = row_in ^ flip_mask;

    // The newest row enters cell zero and older rows move one cell further on,
    // so cell k holds the row that came k+1 stores ago in this table.
    for (genvar k = 0; k < MAX_ROWS; k++) begin : g_cell
        cell_ctl_t        ctl;
        logic [ROW_W-1:0] chain_in;

        if (k == 0) begin : g_head
            assign chain_in = row_in;
        end else begin : g_body
            assign chain_in = cell_row[k-1];
        end

        assign ctl.shift_en   = s_accept && !store_full;
        assign ctl.compare_en = flip_in_row && (CNT_W'(k) < row_count_reg);

        frpd_cell #(
            .ROW_W (ROW_W)
        ) u_cell (
            .aclk    (aclk),
            .ctl     (ctl),
            .row_in  (chain_in),
            .target  (target),
            .row_out (cell_row[k]),
            .match   (match_vec[k])
        );
    end

    // The result reflects this row's compare; the flags then return to zero at
    // the end of a table.
    assign found_flag_next    = found_flag_reg || (|match_vec);
    assign overflow_flag_next = overflow_flag_reg || store_full;
    assign row_count_next     = store_full ? row_count_reg : row_count_reg + CNT_W'(1);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            flip_factor_reg   <= '0;
            row_count_reg     <= '0;
            found_flag_reg    <= 1'b0;
            overflow_flag_reg <= 1'b0;
            m_tvalid_reg      <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                flip_factor_reg <= cfg_wr_data;
            end
            if (s_accept) begin
                if (s_tlast) begin
                    row_count_reg     <= '0;
                    found_flag_reg    <= 1'b0;
                    overflow_flag_reg <= 1'b0;
                end else begin
                    row_count_reg     <= row_count_next;
                    found_flag_reg    <= found_flag_next;
                    overflow_flag_reg <= overflow_flag_next;
                end
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    // Result payload; it needs no reset because valid guards it.
    always_ff @(posedge aclk) begin
        if (s_accept) begin
            m_tdata_reg <= {(M_DATA_W - 2)'(0), overflow_flag_next, found_flag_next};
            m_tlast_reg <= s_tlast;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tlast  = m_tlast_reg;

    // The fill count never passes the number of cells.
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        row_count_reg <= CNT_W'(MAX_ROWS))
        else $error("row count beyond store capacity");

    // The end of a table clears the count and both flags.
    a_table_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        s_accept && s_tlast |=>
            (row_count_reg == '0) && !found_flag_reg && !overflow_flag_reg)
        else $error("table state not cleared after last row");

    // A stored row that does not close the table advances the count by exactly one.
    a_count_step: assert property (@(posedge aclk) disable iff (!aresetn)
        s_accept && !s_tlast && !store_full |=>
            row_count_reg == $past(row_count_reg) + CNT_W'(1))
        else $error("row count did not advance");

    // Overflow is reported only when the store was already full or flagged.
    a_overflow_cause: assert property (@(posedge aclk) disable iff (!aresetn)
        s_accept |=> !m_tdata[1] || $past(store_full) || $past(overflow_flag_reg))
        else $error("overflow reported without a full store");

endmodule

`default_nettype wire

FILE: tb/sv/flipped_row_pair_detector_top_tb.sv
// Self-checking testbench for the flipped row pair detector top level.
`default_nettype none

module flipped_row_pair_detector_top_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import frpd_pkg::*;

    // Depth of the row store and the highest factor index that can be flipped.
    localparam int unsigned STORE_DEPTH = 64;
    localparam logic [FLIP_W-1:0] FLIP_LOW = '0;
    localparam logic [FLIP_W-1:0] FLIP_TOP = '1;
    localparam int unsigned MAX_GAP = 19;
    localparam int unsigned PHASES = 10;
    localparam int unsigned ROWS_PER_PHASE = 140;

    // What the block should answer for one row transaction.
    typedef struct packed {
        logic duplicate;
        logic overflow;
        logic last;
    } row_verdict_t;

    logic                  aclk        = 1'b0;
    logic                  aresetn     = 1'b0;
    logic                  cfg_wr_en   = 1'b0;
    logic [FLIP_W-1:0]     cfg_wr_data = '0;
    logic                  s_tvalid    = 1'b0;
    logic                  s_tready;
    logic [ROW_BITS_W-1:0] s_tdata     = '0;
    logic                  s_tlast     = 1'b0;
    logic                  m_tvalid;
    logic                  m_tready    = 1'b0;
    logic [M_DATA_W-1:0]   m_tdata;
    logic                  m_tlast;

    flipped_row_pair_detector_top u_top (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tlast     (s_tlast),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tlast     (m_tlast)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    // Our own copy of the detector state: the rows of the current table, how
    // many of them are held, the sticky match and overflow flags, and the
    // factor index that is inverted for the comparison.
    logic [ROW_BITS_W-1:0] table_rows [STORE_DEPTH];
    int unsigned           rows_held       = 0;
    logic                  pair_found      = 1'b0;
    logic                  store_overflow  = 1'b0;
    logic [FLIP_W-1:0]     flip_index      = FLIP_LOW;

    // Verdicts waiting for their result transaction, oldest first.
    row_verdict_t pending_verdicts [$];

    // Run statistics and the error tally.
    int unsigned errors          = 0;
    int unsigned rows_sent       = 0;
    int unsigned tables_closed   = 0;
    int unsigned tables_paired   = 0;
    int unsigned tables_overflow = 0;
    int unsigned flip_writes     = 0;

    // When set, neither side inserts idle cycles, giving back-to-back traffic.
    bit no_gaps = 1'b0;

    // Works out the verdict for one accepted row and advances the state. The
    // row is compared with every held row before it is stored itself, so a
    // row can never pair with itself. A row that finds the store full is still
    // compared but is dropped, and the overflow flag is raised until the table
    // closes. The verdict of the closing row is formed before the state clears.
    function automatic row_verdict_t judge_row(input logic [ROW_BITS_W-1:0] row,
                                               input logic last);
        row_verdict_t          verdict;
        logic [ROW_BITS_W-1:0] partner;
        partner = row ^ (ROW_BITS_W'(1) << flip_index);
        for (int unsigned i = 0; i < rows_held; i++) begin
            if (table_rows[i] === partner) begin
                pair_found = 1'b1;
            end
        end
        if (rows_held < STORE_DEPTH) begin
            table_rows[rows_held] = row;
            rows_held++;
        end else begin
            store_overflow = 1'b1;
        end
        verdict.duplicate = pair_found;
        verdict.overflow  = store_overflow;
        verdict.last      = last;
        if (last) begin
            tables_closed++;
            if (pair_found) begin
                tables_paired++;
            end
            if (store_overflow) begin
                tables_overflow++;
            end
            rows_held      = 0;
            pair_found     = 1'b0;
            store_overflow = 1'b0;
        end
        return verdict;
    endfunction

    function automatic void compare_field(input string field, input logic want,
                                          input logic got);
        if (got !== want) begin
            errors++;
            $display("%0t: %s mismatch, expected %0b, actual %0b", $time, field, want, got);
        end
    endfunction

    // Sends one row transaction. An idle gap is drawn first; with no gap the
    // valid stays high from the previous transaction, so it is only ever
    // raised here and lowered either here or in drain_results.
    task automatic send_row(input logic [ROW_BITS_W-1:0] row, input logic last);
        int unsigned gap;
        gap = no_gaps ? 0 : $urandom_range(0, MAX_GAP);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= row;
        s_tlast  <= last;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        pending_verdicts.push_back(judge_row(row, last));
        rows_sent++;
    endtask

    // Holds the input back until every outstanding result has been taken,
    // then lets the output register settle before returning.
    task automatic drain_results();
        s_tvalid <= 1'b0;
        while (pending_verdicts.size() > 0) @(posedge aclk);
        repeat (3) @(posedge aclk);
    endtask

    // The flip factor is only changed while the detector is idle.
    task automatic set_flip(input logic [FLIP_W-1:0] factor);
        drain_results();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= factor;
        @(posedge aclk);
        cfg_wr_en   <= 1'b0;
        flip_index  = factor;
        flip_writes++;
    endtask

    // Result side: every result transaction is checked against the oldest
    // waiting verdict, then a fresh stall is drawn before the next one.
    int unsigned rx_wait = 0;

    always @(posedge aclk) begin : result_side
        row_verdict_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_verdicts.size() == 0) begin
                errors++;
                $display("%0t: result with no row outstanding, expected none, actual %b",
                         $time, {m_tlast, m_tdata});
            end else begin
                want = pending_verdicts.pop_front();
                compare_field("duplicate", want.duplicate, m_tdata[0]);
                compare_field("overflow", want.overflow, m_tdata[1]);
                compare_field("last_result", want.last, m_tlast);
            end
            rx_wait = no_gaps ? 0 : $urandom_range(0, MAX_GAP);
        end
        if (rx_wait > 0) begin
            m_tready <= 1'b0;
            rx_wait--;
        end else begin
            m_tready <= 1'b1;
        end
    end

    // The flip factor must come out of reset as zero: a pair that differs only
    // in factor 0 is found without any register write. The full-width rows
    // repeat the same pair with every other bit of the row set.
    task automatic test_reset_flip();
        send_row(32'h0000_0000, 1'b0);
        send_row(32'h0000_0001, 1'b1);
        send_row(32'hFFFF_FFFF, 1'b0);
        send_row(32'hFFFF_FFFE, 1'b1);
    endtask

    // The top factor index pairs rows that differ only in the most significant
    // bit. Once found, the match must stay set for the rest of the table.
    task automatic test_top_factor();
        set_flip(FLIP_TOP);
        send_row(32'hFFFF_FFFF, 1'b0);
        send_row(32'h7FFF_FFFF, 1'b0);
        send_row(32'h1234_5678, 1'b0);
        send_row(32'hAAAA_AAAA, 1'b1);
    endtask

    // Identical rows, rows differing in some other bit and a partner that sat
    // in the previous table must all fail to pair.
    task automatic test_near_misses();
        set_flip(5'd7);
        send_row(32'h5555_5555, 1'b0);
        send_row(32'h5555_5555, 1'b0);
        send_row(32'h5555_55D4, 1'b0);
        send_row(32'hD555_5555, 1'b1);
        send_row(32'h5555_55D5, 1'b1);
    endtask

    // A single-row table, then a pair completed by the closing row itself.
    task automatic test_pair_on_last_row();
        set_flip(5'd16);
        send_row(32'h0001_0000, 1'b1);
        send_row(32'h0000_0000, 1'b0);
        send_row(32'h0001_0000, 1'b1);
    endtask

    // Fills the store with rows that cannot pair, then sends rows that find it
    // full: one of them pairs with a held row, so both flags must rise and
    // hold until the table closes. The next table must start clean.
    task automatic test_store_full();
        set_flip(5'd3);
        for (int unsigned i = 0; i < STORE_DEPTH; i++) begin
            send_row(ROW_BITS_W'(i) << 4, 1'b0);
        end
        send_row(32'hFFFF_FFF7, 1'b0);
        send_row((ROW_BITS_W'(5) << 4) | 32'h8, 1'b0);
        send_row(32'h0000_0000, 1'b1);
        send_row(32'h0000_0008, 1'b1);
    endtask

    // Random tables over several flip factors, the two extremes among them.
    // Most rows are drawn around a per-table base so that flipped pairs turn
    // up often; the rest differ in one random bit or are wholly random. A few
    // tables run past the store depth. Two phases run without idle cycles.
    task automatic test_random_tables();
        int unsigned           phase_rows;
        int unsigned           table_len;
        int unsigned           bit_a;
        int unsigned           bit_b;
        logic [ROW_BITS_W-1:0] base;
        logic [ROW_BITS_W-1:0] flip_mask;
        logic [ROW_BITS_W-1:0] row;
        for (int unsigned phase = 0; phase < PHASES; phase++) begin
            case (phase)
                0: begin
                    set_flip(FLIP_LOW);
                end
                1: begin
                    set_flip(FLIP_TOP);
                end
                default: begin
                    set_flip(FLIP_W'($urandom_range(0, 31)));
                end
            endcase
            no_gaps    = (phase == 3) || (phase == 7);
            flip_mask  = ROW_BITS_W'(1) << flip_index;
            phase_rows = 0;
            while (phase_rows < ROWS_PER_PHASE) begin
                table_len = ($urandom_range(0, 11) == 0) ? $urandom_range(60, 70)
                                                         : $urandom_range(1, 10);
                base  = $urandom;
                bit_a = $urandom_range(0, 31);
                bit_b = $urandom_range(0, 31);
                for (int unsigned r = 0; r < table_len; r++) begin
                    case ($urandom_range(0, 9))
                        0, 1, 2, 3, 4, 5: begin
                            row = base;
                            if ($urandom_range(0, 1)) row ^= flip_mask;
                            if ($urandom_range(0, 1)) row ^= ROW_BITS_W'(1) << bit_a;
                            if ($urandom_range(0, 1)) row ^= ROW_BITS_W'(1) << bit_b;
                        end
                        6, 7, 8: begin
                            row = base ^ (ROW_BITS_W'(1) << $urandom_range(0, 31));
                        end
                        default: begin
                            row = $urandom;
                        end
                    endcase
                    send_row(row, r == table_len - 1);
                end
                phase_rows += table_len;
            end
        end
        no_gaps = 1'b0;
    endtask

    initial begin
        aresetn <= 1'b0;
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_reset_flip();
        test_top_factor();
        test_near_misses();
        test_pair_on_last_row();
        test_store_full();
        test_random_tables();

        drain_results();
        $display("Run covered %0d rows in %0d tables across %0d flip factor settings.",
                 rows_sent, tables_closed, flip_writes);
        $display("%0d tables closed with a flipped pair and %0d with an overfull store.",
                 tables_paired, tables_overflow);
        if (errors == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

    // Guard against a stalled handshake: far beyond the slowest legal run.
    initial begin
        #5ms;
        $display("Some tests failed");
        $finish;
    end

endmodule

`default_nettype wire
